@@ src/ceau_pkg.sv @@
// Shared types and constants for the CPU effective address unit.
`default_nettype none

package ceau_pkg;

    // Addressing modes as they arrive on the request channel.
    typedef enum logic [3:0] {
        AM_IMM  = 4'd0,
        AM_ZP   = 4'd1,
        AM_ZPX  = 4'd2,
        AM_ZPY  = 4'd3,
        AM_REL  = 4'd4,
        AM_ABS  = 4'd5,
        AM_ABX  = 4'd6,
        AM_ABY  = 4'd7,
        AM_IND  = 4'd8,
        AM_IZX  = 4'd9,
        AM_IZY  = 4'd10,
        AM_IMPL = 4'd11
    } t_am;

    // Input item kinds.
    localparam logic ITEM_REQUEST   = 1'b0;
    localparam logic ITEM_READ_DATA = 1'b1;

    // Result kinds.
    localparam logic RES_READ_REQ = 1'b0;
    localparam logic RES_FINAL    = 1'b1;

    // Pointer fetch phases.
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LOW  = 2'd1,
        PH_HIGH = 2'd2
    } t_phase;

    // Operation the back end performs on a queued job.
    typedef enum logic [1:0] {
        OP_PASS = 2'd0,   // address = base
        OP_ZP   = 2'd1,   // address = (base low byte + offset) mod 256
        OP_REL  = 2'd2,   // address = base + sign-extended offset, flag page change
        OP_IDX  = 2'd3    // address = base + zero-extended offset, flag page change
    } t_op;

    typedef struct packed {
        t_op         op;
        logic        kind;
        logic [15:0] base;
        logic [7:0]  offset;
    } t_job;

    typedef struct packed {
        logic        kind;
        logic [15:0] address;
        logic        crossed;
    } t_result;

    localparam int unsigned QueueDepth = 2;

endpackage

`default_nettype wire

@@ src/cpu_effective_address_unit.sv @@
// Top level of the CPU effective address unit: front end, job queue and back end.
//
// The input channel is a queue write port: an item transfers on a rising edge with
// push high and full low. An item is either a new address request (mode 0) or a byte
// of pointer data returned from memory (mode 1). The result channel is a queue read
// port: while empty is low the oldest result sits on the o_ ports, and it transfers on
// a rising edge with pop high. A result is either a byte read request or the final
// effective address with its page-crossing flag.
// Each item yields at most one result. Its job is registered in the job queue, and the
// result is registered in the result queue before it sits on the o_ ports; a full
// result queue holds the job back in the job queue.
// One item can transfer every cycle while full is low, and a result can leave every
// cycle while empty is low; the two 16-bit adders in the back end set the timing path.
// Indirect modes issue two read requests, low byte first; the block expects the two
// returned bytes as later mode 1 items. Data arriving with no fetch in flight is
// dropped, and a new request abandons any fetch in progress.
// When the receiver stalls, the result queue fills, then the job queue, and full
// rises; nothing is lost. Synchronous active-low reset empties both queues and
// returns the fetch tracker to idle.
`default_nettype none

module cpu_effective_address_unit import ceau_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_mode,
    input  wire logic [3:0]  i_addressing_mode,
    input  wire logic [15:0] i_operand,
    input  wire logic [7:0]  i_index_x,
    input  wire logic [7:0]  i_index_y,
    input  wire logic [15:0] i_program_counter,
    input  wire logic [7:0]  i_read_data,
    output logic             empty,
    input  wire logic        pop,
    output logic             o_result_kind,
    output logic [15:0]      o_address,
    output logic             o_page_crossed
);

    logic    w_accept;
    logic    w_job_push;
    t_job    w_job_in;
    logic    w_job_valid;
    logic    w_job_pop;
    t_job    w_job_out;
    t_result w_result;

    // The front end's state only advances on a real transfer.
    assign w_accept = push && !full;

    ceau_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (w_accept),
        .i_mode            (i_mode),
        .i_addressing_mode (i_addressing_mode),
        .i_operand         (i_operand),
        .i_index_x         (i_index_x),
        .i_index_y         (i_index_y),
        .i_program_counter (i_program_counter),
        .i_read_data       (i_read_data),
        .o_job_push        (w_job_push),
        .o_job             (w_job_in)
    );

    ceau_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_job   (w_job_in),
        .o_full  (full),
        .o_valid (w_job_valid),
        .i_pop   (w_job_pop),
        .o_job   (w_job_out)
    );

    ceau_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job_out),
        .o_job_pop   (w_job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (w_result)
    );

    assign o_result_kind  = w_result.kind;
    assign o_address      = w_result.address;
    assign o_page_crossed = w_result.crossed;

endmodule

`default_nettype wire

@@ src/ceau_front.sv @@
// Front end: accepts items, tracks the pointer fetch and classifies each item into a job.
`default_nettype none

module ceau_front import ceau_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic        i_mode,
    input  wire logic [3:0]  i_addressing_mode,
    input  wire logic [15:0] i_operand,
    input  wire logic [7:0]  i_index_x,
    input  wire logic [7:0]  i_index_y,
    input  wire logic [15:0] i_program_counter,
    input  wire logic [7:0]  i_read_data,
    output logic             o_job_push,
    output t_job             o_job
);

    t_phase      r_phase, n_phase;
    t_am         r_pending, n_pending;
    logic [15:0] r_ptr_addr, n_ptr_addr;
    logic [7:0]  r_ptr_lo, n_ptr_lo;
    logic [7:0]  r_saved_y, n_saved_y;

    logic [7:0]  w_lo;
    logic [7:0]  w_lo_x;
    t_am         w_am;

    assign w_lo   = i_operand[7:0];
    assign w_lo_x = w_lo + i_index_x;
    assign w_am   = t_am'(i_addressing_mode);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
        r_pending  <= n_pending;
        r_ptr_addr <= n_ptr_addr;
        r_ptr_lo   <= n_ptr_lo;
        r_saved_y  <= n_saved_y;
    end

    always_comb begin
        n_phase    = r_phase;
        n_pending  = r_pending;
        n_ptr_addr = r_ptr_addr;
        n_ptr_lo   = r_ptr_lo;
        n_saved_y  = r_saved_y;
        o_job_push = 1'b0;
        o_job      = '{op: OP_PASS, kind: RES_FINAL, base: i_operand, offset: 8'h00};

        if (i_accept) begin
            n_phase = PH_IDLE;
            if (i_mode == ITEM_READ_DATA) begin
                unique case (r_phase)
                    PH_LOW: begin
                        n_ptr_lo   = i_read_data;
                        n_phase    = PH_HIGH;
                        o_job_push = 1'b1;
                        o_job      = '{op: OP_PASS, kind: RES_READ_REQ,
                                       base: r_ptr_addr, offset: 8'h00};
                    end
                    PH_HIGH: begin
                        o_job_push = 1'b1;
                        if (r_pending == AM_IZY) begin
                            o_job = '{op: OP_IDX, kind: RES_FINAL,
                                      base: {i_read_data, r_ptr_lo}, offset: r_saved_y};
                        end else begin
                            o_job = '{op: OP_PASS, kind: RES_FINAL,
                                      base: {i_read_data, r_ptr_lo}, offset: 8'h00};
                        end
                    end
                    default: begin
                        // Data with no fetch in flight is dropped.
                        o_job_push = 1'b0;
                    end
                endcase
            end else begin
                o_job_push = 1'b1;
                unique case (w_am)
                    AM_IMM, AM_ZP: begin
                        o_job = '{op: OP_PASS, kind: RES_FINAL,
                                  base: {8'h00, w_lo}, offset: 8'h00};
                    end
                    AM_ZPX: begin
                        o_job = '{op: OP_ZP, kind: RES_FINAL, base: i_operand,
                                  offset: i_index_x};
                    end
                    AM_ZPY: begin
                        o_job = '{op: OP_ZP, kind: RES_FINAL, base: i_operand,
                                  offset: i_index_y};
                    end
                    AM_REL: begin
                        o_job = '{op: OP_REL, kind: RES_FINAL, base: i_program_counter,
                                  offset: w_lo};
                    end
                    AM_ABX: begin
                        o_job = '{op: OP_IDX, kind: RES_FINAL, base: i_operand,
                                  offset: i_index_x};
                    end
                    AM_ABY: begin
                        o_job = '{op: OP_IDX, kind: RES_FINAL, base: i_operand,
                                  offset: i_index_y};
                    end
                    AM_IND: begin
                        // The high byte is read within the same page as the low byte.
                        n_pending  = AM_IND;
                        n_ptr_addr = {i_operand[15:8], w_lo + 8'd1};
                        n_phase    = PH_LOW;
                        o_job      = '{op: OP_PASS, kind: RES_READ_REQ, base: i_operand,
                                       offset: 8'h00};
                    end
                    AM_IZX: begin
                        n_pending  = AM_IZX;
                        n_ptr_addr = {8'h00, w_lo_x + 8'd1};
                        n_phase    = PH_LOW;
                        o_job      = '{op: OP_PASS, kind: RES_READ_REQ,
                                       base: {8'h00, w_lo_x}, offset: 8'h00};
                    end
                    AM_IZY: begin
                        n_pending  = AM_IZY;
                        n_ptr_addr = {8'h00, w_lo + 8'd1};
                        n_saved_y  = i_index_y;
                        n_phase    = PH_LOW;
                        o_job      = '{op: OP_PASS, kind: RES_READ_REQ,
                                       base: {8'h00, w_lo}, offset: 8'h00};
                    end
                    default: begin
                        // Absolute, implied and unused codes pass the operand through.
                        o_job = '{op: OP_PASS, kind: RES_FINAL, base: i_operand,
                                  offset: 8'h00};
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

@@ src/ceau_queue.sv @@
// Two-entry job queue between the front end and the back end.
`default_nettype none

module ceau_queue import ceau_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    output logic      o_valid,
    input  wire logic i_pop,
    output t_job      o_job
);

    t_job       r_mem [QueueDepth];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       w_do_push, w_do_pop;

    assign o_full    = (r_count == 2'(QueueDepth));
    assign o_valid   = (r_count != 2'd0);
    assign o_job     = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = w_do_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_do_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(w_do_push) - 2'(w_do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // The occupancy never exceeds the number of entries.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'(QueueDepth))
        else $error("job queue count out of range");

    // The front end only pushes when the top level has let an item in.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("job pushed into a full queue");

endmodule

`default_nettype wire

@@ src/ceau_back.sv @@
// Back end: address arithmetic on queued jobs and the two-entry result queue.
`default_nettype none

module ceau_back import ceau_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_valid,
    input  wire t_job i_job,
    output logic      o_job_pop,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_result   o_result
);

    t_result    r_mem [QueueDepth];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       w_do_pop;
    t_result    w_res;
    logic [15:0] w_sum;

    always_comb begin
        w_sum = 16'h0000;
        w_res = '{kind: i_job.kind, address: i_job.base, crossed: 1'b0};
        case (i_job.op)
            OP_ZP: begin
                w_res.address = {8'h00, i_job.base[7:0] + i_job.offset};
            end
            OP_REL: begin
                w_sum         = i_job.base + {{8{i_job.offset[7]}}, i_job.offset};
                w_res.address = w_sum;
                w_res.crossed = (w_sum[15:8] != i_job.base[15:8]);
            end
            OP_IDX: begin
                w_sum         = i_job.base + {8'h00, i_job.offset};
                w_res.address = w_sum;
                w_res.crossed = (w_sum[15:8] != i_job.base[15:8]);
            end
            default: begin
                w_res.address = i_job.base;
            end
        endcase
    end

    assign o_empty   = (r_count == 2'd0);
    assign o_result  = r_mem[r_rd_ptr];
    assign o_job_pop = i_job_valid && (r_count != 2'(QueueDepth));
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = o_job_pop ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_do_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(o_job_pop) - 2'(w_do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (o_job_pop) begin
            r_mem[r_wr_ptr] <= w_res;
        end
    end

    // A read request never carries a page crossing.
    a_cross_only_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop && w_res.crossed |-> w_res.kind == RES_FINAL)
        else $error("page crossing flagged on a read request");

    // A result transfer with no new job lowers the occupancy by one.
    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_pop && !o_job_pop |=> r_count == $past(r_count) - 2'd1)
        else $error("result queue count did not drop after a transfer");

endmodule

`default_nettype wire

@@ verif/cpu_effective_address_unit_tb.sv @@
// Self-checking testbench for the CPU effective address unit.
`timescale 1ns / 1ps

module cpu_effective_address_unit_tb;
    import ceau_pkg::*;

    // Any cycle in which neither side completes a transfer counts toward this limit.
    localparam int STALL_LIMIT = 1000;
    // A result passes the job queue and then the result queue after its item; this pause covers that with margin.
    localparam int SETTLE_CYCLES = 8;
    // Mismatches beyond this count are still counted but no longer printed.
    localparam int PRINT_LIMIT = 40;
    localparam int ITEMS_PER_PHASE = 480;
    localparam int NUM_PHASES = 4;
    // Highest undefined addressing mode code; it must behave like implied.
    localparam logic [3:0] AM_UNDEF_TOP = 4'hf;

    // One input item, with every field the input channel carries.
    typedef struct packed {
        logic        mode;
        logic [3:0]  am;
        logic [15:0] operand;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [15:0] pc;
        logic [7:0]  data;
    } t_addr_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        i_mode = 1'b0;
    logic [3:0]  i_addressing_mode = 4'h0;
    logic [15:0] i_operand = 16'h0000;
    logic [7:0]  i_index_x = 8'h00;
    logic [7:0]  i_index_y = 8'h00;
    logic [15:0] i_program_counter = 16'h0000;
    logic [7:0]  i_read_data = 8'h00;
    logic        empty;
    logic        pop = 1'b0;
    logic        o_result_kind;
    logic [15:0] o_address;
    logic        o_page_crossed;

    cpu_effective_address_unit u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_mode            (i_mode),
        .i_addressing_mode (i_addressing_mode),
        .i_operand         (i_operand),
        .i_index_x         (i_index_x),
        .i_index_y         (i_index_y),
        .i_program_counter (i_program_counter),
        .i_read_data       (i_read_data),
        .empty             (empty),
        .pop               (pop),
        .o_result_kind     (o_result_kind),
        .o_address         (o_address),
        .o_page_crossed    (o_page_crossed)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Items waiting to be driven, and the results the block still owes us.
    t_addr_item item_queue[$];
    t_result    address_due[$];

    // Our own copy of the pointer-fetch tracker, mirroring the block's state.
    t_phase      fetch_state = PH_IDLE;
    logic [3:0]  fetch_am = 4'h0;
    logic [15:0] ptr_fetch_addr = 16'h0000;
    logic [7:0]  ptr_low = 8'h00;
    logic [7:0]  izy_index = 8'h00;

    // Idle rates for the current phase, in percent.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int send_idle_by_phase[NUM_PHASES] = '{0, 62, 0, 9};
    int recv_stall_by_phase[NUM_PHASES] = '{0, 0, 62, 9};

    // Handshake status seen at the last rising edge.
    bit item_taken = 1'b0;
    bit result_taken = 1'b0;
    int quiet_cycles = 0;

    int mismatch_count = 0;
    int request_items = 0;
    int data_items = 0;
    int read_results = 0;
    int final_results = 0;
    int crossings = 0;
    int stim_count = 0;
    int stim_goal;
    int scenario;
    int phase;
    logic [3:0] rand_am;

    t_addr_item next_item;
    t_addr_item seen_item;
    t_result    want;
    t_result    predicted;
    bit         has_result;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] wanted);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got,
                     wanted);
        end
    endtask

    // Works out the result, if any, that one accepted item causes, and advances the
    // local copy of the fetch tracker exactly as the block should.
    task automatic predict_address(input t_addr_item it, output bit produces,
                                   output t_result res);
        logic [7:0]  lo;
        logic [7:0]  zsum;
        logic [15:0] ptr;
        logic [15:0] addr;
        logic [15:0] offset;
        lo = it.operand[7:0];
        res = '0;
        produces = 1'b1;
        if (it.mode == ITEM_READ_DATA) begin
            case (fetch_state)
                PH_LOW: begin
                    // Low pointer byte is in; ask for the high byte next.
                    ptr_low = it.data;
                    fetch_state = PH_HIGH;
                    res.kind = RES_READ_REQ;
                    res.address = ptr_fetch_addr;
                end
                PH_HIGH: begin
                    ptr = {it.data, ptr_low};
                    fetch_state = PH_IDLE;
                    res.kind = RES_FINAL;
                    if (fetch_am == AM_IZY) begin
                        addr = ptr + {8'h00, izy_index};
                        res.address = addr;
                        res.crossed = (addr[15:8] != ptr[15:8]);
                    end else begin
                        res.address = ptr;
                    end
                end
                default: begin
                    // Returned data with no fetch in flight is dropped.
                    fetch_state = PH_IDLE;
                    produces = 1'b0;
                end
            endcase
        end else begin
            // Any new request abandons a fetch that is still in progress.
            fetch_state = PH_IDLE;
            res.kind = RES_FINAL;
            case (it.am)
                AM_IMM, AM_ZP: begin
                    res.address = {8'h00, lo};
                end
                AM_ZPX: begin
                    zsum = lo + it.x;
                    res.address = {8'h00, zsum};
                end
                AM_ZPY: begin
                    zsum = lo + it.y;
                    res.address = {8'h00, zsum};
                end
                AM_REL: begin
                    offset = {{8{lo[7]}}, lo};
                    addr = it.pc + offset;
                    res.address = addr;
                    res.crossed = (addr[15:8] != it.pc[15:8]);
                end
                AM_ABS: begin
                    res.address = it.operand;
                end
                AM_ABX: begin
                    addr = it.operand + {8'h00, it.x};
                    res.address = addr;
                    res.crossed = (addr[15:8] != it.operand[15:8]);
                end
                AM_ABY: begin
                    addr = it.operand + {8'h00, it.y};
                    res.address = addr;
                    res.crossed = (addr[15:8] != it.operand[15:8]);
                end
                AM_IND: begin
                    // The high byte comes from the same page: the well-known wrap quirk.
                    zsum = lo + 8'd1;
                    fetch_am = it.am;
                    ptr_fetch_addr = {it.operand[15:8], zsum};
                    fetch_state = PH_LOW;
                    res.kind = RES_READ_REQ;
                    res.address = it.operand;
                end
                AM_IZX: begin
                    zsum = lo + it.x;
                    fetch_am = it.am;
                    ptr_fetch_addr = {8'h00, zsum + 8'd1};
                    fetch_state = PH_LOW;
                    res.kind = RES_READ_REQ;
                    res.address = {8'h00, zsum};
                end
                AM_IZY: begin
                    zsum = lo + 8'd1;
                    fetch_am = it.am;
                    ptr_fetch_addr = {8'h00, zsum};
                    izy_index = it.y;
                    fetch_state = PH_LOW;
                    res.kind = RES_READ_REQ;
                    res.address = {8'h00, lo};
                end
                default: begin
                    // Implied and the undefined codes pass the operand through.
                    res.address = it.operand;
                end
            endcase
        end
    endtask

    task automatic queue_request(input logic [3:0] am, input logic [15:0] operand,
                                 input logic [7:0] x, input logic [7:0] y,
                                 input logic [15:0] pc);
        t_addr_item it;
        it.mode = ITEM_REQUEST;
        it.am = am;
        it.operand = operand;
        it.x = x;
        it.y = y;
        it.pc = pc;
        it.data = 8'($urandom_range(255));
        item_queue.push_back(it);
    endtask

    // A returned memory byte; the request fields ride along with random content.
    task automatic queue_data(input logic [7:0] d);
        t_addr_item it;
        it.mode = ITEM_READ_DATA;
        it.am = 4'($urandom_range(15));
        it.operand = 16'($urandom_range(65535));
        it.x = 8'($urandom_range(255));
        it.y = 8'($urandom_range(255));
        it.pc = 16'($urandom_range(65535));
        it.data = d;
        item_queue.push_back(it);
    endtask

    task automatic queue_random_request(input logic [3:0] am);
        queue_request(am, 16'($urandom_range(65535)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 16'($urandom_range(65535)));
    endtask

    // Returns at a rising edge once every item has transferred and every result is back.
    task automatic wait_drained();
        while (item_queue.size() != 0 || push || address_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Driver: everything changes on the falling edge. An item stays on the ports
    // until a transfer takes it, and the next one may follow without a gap, so push
    // gets at most one assignment per edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
            if (!push || item_taken) begin
                if (item_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_item = item_queue.pop_front();
                    i_mode <= next_item.mode;
                    i_addressing_mode <= next_item.am;
                    i_operand <= next_item.operand;
                    i_index_x <= next_item.x;
                    i_index_y <= next_item.y;
                    i_program_counter <= next_item.pc;
                    i_read_data <= next_item.data;
                    push <= 1'b1;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: samples both channels at the rising edge. Outputs are checked against
    // the oldest outstanding expectation, then any accepted input item is run through
    // the predictor. The watchdog runs last so that nothing follows its exit.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_taken = 1'b0;
            result_taken = 1'b0;
        end else begin
            item_taken = push && !full;
            result_taken = pop && !empty;

            if (result_taken) begin
                if (o_result_kind == RES_READ_REQ) begin
                    read_results++;
                end else begin
                    final_results++;
                end
                if (o_page_crossed === 1'b1) begin
                    crossings++;
                end
                if (address_due.size() == 0) begin
                    report_mismatch("unexpected result, address", o_address, 16'h0000);
                end else begin
                    want = address_due.pop_front();
                    if (o_result_kind !== want.kind) begin
                        report_mismatch("result kind", 16'(o_result_kind), 16'(want.kind));
                    end
                    if (o_address !== want.address) begin
                        report_mismatch("address", o_address, want.address);
                    end
                    if (o_page_crossed !== want.crossed) begin
                        report_mismatch("page crossed", 16'(o_page_crossed),
                                        16'(want.crossed));
                    end
                end
            end

            if (item_taken) begin
                seen_item.mode = i_mode;
                seen_item.am = i_addressing_mode;
                seen_item.operand = i_operand;
                seen_item.x = i_index_x;
                seen_item.y = i_index_y;
                seen_item.pc = i_program_counter;
                seen_item.data = i_read_data;
                if (i_mode == ITEM_READ_DATA) begin
                    data_items++;
                end else begin
                    request_items++;
                end
                predict_address(seen_item, has_result, predicted);
                if (has_result) begin
                    address_due.push_back(predicted);
                end
            end

            if (item_taken || result_taken) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout: no transfer on either side for %0d cycles", STALL_LIMIT);
                $display("[cpu_effective_address_unit] ERROR");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, run with both sides always ready.
        queue_request(AM_IMM, 16'hffff, 8'h00, 8'h00, 16'h0000);
        queue_request(AM_ZP, 16'h0000, 8'hff, 8'hff, 16'hffff);
        // Zero-page indexing has to wrap inside page zero.
        queue_request(AM_ZPX, 16'hffff, 8'hff, 8'h00, 16'h0000);
        queue_request(AM_ZPY, 16'h1280, 8'h00, 8'h80, 16'h0000);
        // Branches: forward across a page, backward wrapping below zero, and a short hop.
        queue_request(AM_REL, 16'h007f, 8'h00, 8'h00, 16'h12f0);
        queue_request(AM_REL, 16'h0080, 8'h00, 8'h00, 16'h0000);
        queue_request(AM_REL, 16'h0005, 8'h00, 8'h00, 16'h1280);
        queue_request(AM_ABS, 16'hffff, 8'h00, 8'h00, 16'h0000);
        // Absolute indexed wrapping past the top of memory, and one inside a page.
        queue_request(AM_ABX, 16'hffff, 8'hff, 8'h00, 16'h0000);
        queue_request(AM_ABY, 16'h1200, 8'h00, 8'h10, 16'h0000);
        // Indirect with the pointer on a page's last byte: high byte from the same page.
        queue_request(AM_IND, 16'h10ff, 8'h00, 8'h00, 16'h0000);
        queue_data(8'h34);
        queue_data(8'h12);
        // Indexed-indirect where the pointer's second byte wraps to zero.
        queue_request(AM_IZX, 16'h00fe, 8'h01, 8'h00, 16'h0000);
        queue_data(8'h00);
        queue_data(8'h80);
        // Indirect-indexed with pointer at the end of page zero and a wrapping sum.
        queue_request(AM_IZY, 16'h00ff, 8'h00, 8'hff, 16'h0000);
        queue_data(8'hff);
        queue_data(8'hff);
        queue_request(AM_IMPL, 16'ha5a5, 8'h00, 8'h00, 16'h0000);
        queue_request(AM_UNDEF_TOP, 16'h5a5a, 8'hff, 8'hff, 16'hffff);
        // Data while idle is dropped; a new request abandons a half-done fetch.
        queue_data(8'h77);
        queue_request(AM_IND, 16'h2000, 8'h00, 8'h00, 16'h0000);
        queue_data(8'h11);
        queue_request(AM_ABS, 16'h0400, 8'h00, 8'h00, 16'h0000);
        queue_data(8'h99);
        wait_drained();

        // Random part, one phase per idling pattern. Most traffic is complete
        // pointer fetches or plain requests; the rest abandons fetches or sends
        // bytes nobody asked for.
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            send_idle_pct = send_idle_by_phase[phase];
            recv_stall_pct = recv_stall_by_phase[phase];
            stim_goal = stim_count + ITEMS_PER_PHASE;
            while (stim_count < stim_goal) begin
                scenario = $urandom_range(99);
                if (scenario < 40) begin
                    rand_am = 4'($urandom_range(12));
                    if (rand_am >= AM_IND) begin
                        rand_am = rand_am + 4'd3;
                    end
                    queue_random_request(rand_am);
                    stim_count += 1;
                end else if (scenario < 85) begin
                    queue_random_request(4'(AM_IND + $urandom_range(2)));
                    queue_data(8'($urandom_range(255)));
                    queue_data(8'($urandom_range(255)));
                    stim_count += 3;
                end else if (scenario < 93) begin
                    queue_random_request(4'(AM_IND + $urandom_range(2)));
                    stim_count += 1;
                    if ($urandom_range(1) == 1) begin
                        queue_data(8'($urandom_range(255)));
                        stim_count += 1;
                    end
                end else begin
                    queue_data(8'($urandom_range(255)));
                    stim_count += 1;
                end
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (address_due.size() != 0) begin
            want = address_due.pop_front();
            report_mismatch("missing result, address", 16'h0000, want.address);
        end

        $display("Sent %0d address requests and %0d pointer bytes over %0d idling phases.",
                 request_items, data_items, NUM_PHASES);
        $display("Got back %0d read requests and %0d final addresses, %0d with a page crossing.",
                 read_results, final_results, crossings);
        if (mismatch_count == 0) begin
            $display("[cpu_effective_address_unit] OK");
        end else begin
            $display("%0d mismatches in total", mismatch_count);
            $display("[cpu_effective_address_unit] ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/ceau_pkg.sv
src/ceau_front.sv
src/ceau_queue.sv
src/ceau_back.sv
src/cpu_effective_address_unit.sv
verif/cpu_effective_address_unit_tb.sv
